>>> hw/rtl/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types, codes and defaults for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int VALUE_W           = 32;
  localparam int DIM_CFG_W         = 4;
  localparam int IDX_FIELD_W       = 3;
  localparam int CMD_W             = 2;
  localparam int MAX_DIM_DEF       = 8;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_WRITE_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [IDX_FIELD_W-1:0] row_index;
    logic [IDX_FIELD_W-1:0] col_index;
    logic signed [VALUE_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] out_row;
    logic [IDX_FIELD_W-1:0] out_col;
    logic signed [VALUE_W-1:0] product_value;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctrl_t;

endpackage

>>> hw/rtl/mm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_ram
// Element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int WIDTH  = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_mac
// Shared multiply-accumulate unit with shift and saturation of the sum.
// ----------------------------------------------------------------------------
module mm_mac
  import mm_pkg::*;
#(
  parameter int MAX_DIM       = MAX_DIM_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctrl_t                 ctrl,
  input  logic [VALUE_W-1:0]        a_data,
  input  logic [VALUE_W-1:0]        b_data,
  output logic                      busy,
  output logic signed [VALUE_W-1:0] result
);

  localparam int PROD_W = 2 * VALUE_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM + 1) + 1;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    $signed({{(ACC_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    $signed({{(ACC_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}});

  logic                     dv_r, dv_nxt;
  logic                     pv_r, pv_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  shifted;

  always_comb begin
    dv_nxt   = ctrl.issue;
    pv_nxt   = dv_r;
    prod_nxt = dv_r ? ($signed(a_data) * $signed(b_data)) : prod_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      dv_r <= dv_nxt;
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign busy    = dv_r | pv_r;
  assign shifted = acc_r >>> FRACTION_BITS;

  always_comb begin
    if (shifted > SAT_MAX) begin
      result = SAT_MAX[VALUE_W-1:0];
    end else if (shifted < SAT_MIN) begin
      result = SAT_MIN[VALUE_W-1:0];
    end else begin
      result = shifted[VALUE_W-1:0];
    end
  end

endmodule

>>> hw/rtl/mm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_seq
// Command decode, element writes and the i/j/k loop sequencer with result
// register.
// ----------------------------------------------------------------------------
module mm_seq
  import mm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int ADDR_W  = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic [DIM_CFG_W-1:0] rows_a,
  input  logic [DIM_CFG_W-1:0] inner_dim,
  input  logic [DIM_CFG_W-1:0] cols_b,
  output logic                 we_a,
  output logic                 we_b,
  output logic [ADDR_W-1:0]    waddr,
  output logic [VALUE_W-1:0]   wdata,
  output logic [ADDR_W-1:0]    raddr_a,
  output logic [ADDR_W-1:0]    raddr_b,
  output mac_ctrl_t            mac_ctrl,
  input  logic                 mac_busy,
  input  logic [VALUE_W-1:0]   mac_result
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  function automatic logic [ADDR_W-1:0] flat(input logic [ADDR_W-1:0] r,
                                              input logic [ADDR_W-1:0] c);
    return ADDR_W'(r * ADDR_W'(MAX_DIM) + c);
  endfunction

  function automatic logic [DIM_W-1:0] clamp(input logic [DIM_CFG_W-1:0] v);
    return (int'(v) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(v);
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [DIM_W-1:0] nr_r, nr_nxt;
  logic [DIM_W-1:0] nk_r, nk_nxt;
  logic [DIM_W-1:0] nc_r, nc_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic accept;
  logic in_range;
  logic i_last, j_last, k_last;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_range = (int'(in_data.row_index) < MAX_DIM) &&
                    (int'(in_data.col_index) < MAX_DIM);

  assign waddr = flat(ADDR_W'(in_data.row_index), ADDR_W'(in_data.col_index));
  assign wdata = in_data.element_value;
  assign we_a  = accept && in_range && (in_data.command == CMD_WRITE_A);
  assign we_b  = accept && in_range && (in_data.command == CMD_WRITE_B);

  assign raddr_a = flat(ADDR_W'(i_r), ADDR_W'(k_r));
  assign raddr_b = flat(ADDR_W'(k_r), ADDR_W'(j_r));

  assign i_last = (DIM_W'(i_r) + DIM_W'(1)) == nr_r;
  assign j_last = (DIM_W'(j_r) + DIM_W'(1)) == nc_r;
  assign k_last = (DIM_W'(k_r) + DIM_W'(1)) == nk_r;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    nr_nxt        = nr_r;
    nk_nxt        = nk_r;
    nc_nxt        = nc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mac_ctrl      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.command == CMD_MULTIPLY)) begin
          nr_nxt         = clamp(rows_a);
          nk_nxt         = clamp(inner_dim);
          nc_nxt         = clamp(cols_b);
          i_nxt          = '0;
          j_nxt          = '0;
          k_nxt          = '0;
          mac_ctrl.clear = 1'b1;
          if ((clamp(rows_a) != '0) && (clamp(cols_b) != '0)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (nk_r == '0) begin
          state_nxt = ST_DRAIN;
        end else begin
          mac_ctrl.issue = 1'b1;
          if (k_last) begin
            k_nxt     = '0;
            state_nxt = ST_DRAIN;
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && (!out_valid_r || !out_stall)) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_row       = IDX_FIELD_W'(i_r);
          out_data_nxt.out_col       = IDX_FIELD_W'(j_r);
          out_data_nxt.product_value = mac_result;
          out_data_nxt.last          = i_last && j_last;
          mac_ctrl.clear             = 1'b1;
          if (i_last && j_last) begin
            state_nxt = ST_IDLE;
          end else if (j_last) begin
            j_nxt     = '0;
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = ST_RUN;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    nr_r       <= nr_nxt;
    nk_r       <= nk_nxt;
    nc_r       <= nc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/matrix_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_top
// Fixed-point matrix multiplier: element stores for A and B, one shared
// multiply-accumulate unit, loop sequencer and APB register port.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_item_t (command, row, col, value)
//  out_    | output    | out_valid/out_stall| out_item_t (row, col, value, last)
//  APB     | input     | psel/penable       | rows_a, inner_dim, cols_b
//
//  Write commands leave the block idle; it is ready again the next cycle.
//  During a multiply the sequencer takes the product elements in turn; for
//  each it issues one inner step per cycle on the shared multiplier, waits
//  while the store read, multiply and accumulate registers drain, and then
//  loads the result, held by output stalls. With inner 0 an element issues
//  no inner steps.
//  Reset is synchronous, active low; dimension registers reset to 8.
//  The store contents are not cleared by reset.
//  A stalled result holds the sequencer until the result register frees.
// ----------------------------------------------------------------------------
module matrix_multiply_top
  import mm_pkg::*;
#(
  parameter int MAX_DIM       = MAX_DIM_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;

  logic [DIM_CFG_W-1:0] rows_a_r, rows_a_nxt;
  logic [DIM_CFG_W-1:0] inner_dim_r, inner_dim_nxt;
  logic [DIM_CFG_W-1:0] cols_b_r, cols_b_nxt;

  logic               cfg_wr;
  logic               we_a, we_b;
  logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  logic [VALUE_W-1:0] wdata, a_data, b_data;
  logic [VALUE_W-1:0] mac_result;
  logic               mac_busy;
  mac_ctrl_t          mac_ctrl;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    rows_a_nxt    = rows_a_r;
    inner_dim_nxt = inner_dim_r;
    cols_b_nxt    = cols_b_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROWS_A:    rows_a_nxt    = pwdata[DIM_CFG_W-1:0];
        REG_INNER_DIM: inner_dim_nxt = pwdata[DIM_CFG_W-1:0];
        REG_COLS_B:    cols_b_nxt    = pwdata[DIM_CFG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A:    prdata = 32'(rows_a_r);
      REG_INNER_DIM: prdata = 32'(inner_dim_r);
      REG_COLS_B:    prdata = 32'(cols_b_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
    end else begin
      rows_a_r    <= rows_a_nxt;
      inner_dim_r <= inner_dim_nxt;
      cols_b_r    <= cols_b_nxt;
    end
  end

  mm_seq #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .rows_a     (rows_a_r),
    .inner_dim  (inner_dim_r),
    .cols_b     (cols_b_r),
    .we_a       (we_a),
    .we_b       (we_b),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .mac_ctrl   (mac_ctrl),
    .mac_busy   (mac_busy),
    .mac_result (mac_result)
  );

  mm_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .WIDTH  (VALUE_W)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (mac_ctrl.issue),
    .raddr (raddr_a),
    .rdata (a_data)
  );

  mm_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .WIDTH  (VALUE_W)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (mac_ctrl.issue),
    .raddr (raddr_b),
    .rdata (b_data)
  );

  mm_mac #(
    .MAX_DIM       (MAX_DIM),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .a_data (a_data),
    .b_data (b_data),
    .busy   (mac_busy),
    .result (mac_result)
  );

`ifndef ASSERT_OFF
  a_mult_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.command == CMD_MULTIPLY) &&
    (rows_a_r != '0) && (cols_b_r != '0) |=> in_stall)
    else $error("multiply item accepted but block did not go busy");

  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    ((in_data.command == CMD_WRITE_A) || (in_data.command == CMD_WRITE_B))
    |=> !in_stall)
    else $error("element write left the block busy");

  a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !mac_ctrl.issue)
    else $error("multiplier issued while sequencer idle");
`endif

endmodule
